>>> rtl/core/hkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_pkg
// shared widths, register indexes, event codes and word types for the heater
// keep-alive controller
// ----------------------------------------------------------------------------
package hkc_pkg;

    localparam int AGE_W    = 17;
    localparam int ELAPSE_W = 16;
    localparam int TEMP_W   = 10;
    localparam int PERIOD_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PASS_MAX = {PERIOD_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KA_LOST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KA_GOOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_TEMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd5;

    // reset values
    localparam logic [AGE_W-1:0]           KA_LOST_RST   = 17'd75000;
    localparam logic [AGE_W-1:0]           KA_GOOD_RST   = 17'd60000;
    localparam logic [AGE_W-1:0]           COOL_LIM_RST  = 17'd90000;
    localparam logic signed [TEMP_W-1:0]   COOL_TEMP_RST = 10'sd80;
    localparam logic signed [TEMP_W-1:0]   HOT_TEMP_RST  = 10'sd90;
    localparam logic [PERIOD_W-1:0]        PERIOD_RST    = 8'd20;

    // mode codes
    localparam logic MODE_PASS    = 1'b0;
    localparam logic MODE_REFRESH = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OFF      = 2'd0;
    localparam logic [1:0] STAT_FAN      = 2'd1;
    localparam logic [1:0] STAT_STARTING = 2'd2;
    localparam logic [1:0] STAT_ON       = 2'd3;

    // control events
    localparam logic [2:0] CEV_NONE     = 3'd0;
    localparam logic [2:0] CEV_REQ_OFF  = 3'd1;
    localparam logic [2:0] CEV_WDOG     = 3'd2;
    localparam logic [2:0] CEV_LINK_UP  = 3'd3;
    localparam logic [2:0] CEV_REQ_ON   = 3'd4;

    // cooldown events
    localparam logic [1:0] KEV_NONE  = 2'd0;
    localparam logic [1:0] KEV_COOL  = 2'd1;
    localparam logic [1:0] KEV_TIMER = 2'd2;

    typedef struct packed {
        logic [AGE_W-1:0]         ka_lost;
        logic [AGE_W-1:0]         ka_good;
        logic [AGE_W-1:0]         cool_lim;
        logic signed [TEMP_W-1:0] cool_temp;
        logic signed [TEMP_W-1:0] hot_temp;
        logic [PERIOD_W-1:0]      period;
    } cfg_t;

    typedef struct packed {
        logic                     mode;
        logic [ELAPSE_W-1:0]      elapsed_ms;
        logic                     heat_request;
        logic signed [TEMP_W-1:0] temperature_f;
    } item_t;

    typedef struct packed {
        logic       heater_on;
        logic       fan_on;
        logic       status_led;
        logic       status_valid;
        logic [1:0] status_code;
        logic [2:0] control_event;
        logic [1:0] cooldown_event;
    } result_t;

endpackage

>>> rtl/core/hkc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_if
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
interface hkc_item_if;
    import hkc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [ELAPSE_W-1:0]      elapsed_ms;
    logic                     heat_request;
    logic signed [TEMP_W-1:0] temperature_f;

    modport source (
        output valid, mode, elapsed_ms, heat_request, temperature_f,
        input  ready
    );
    modport sink (
        input  valid, mode, elapsed_ms, heat_request, temperature_f,
        output ready
    );
endinterface

interface hkc_result_if;
    logic       valid;
    logic       ready;
    logic       heater_on;
    logic       fan_on;
    logic       status_led;
    logic       status_valid;
    logic [1:0] status_code;
    logic [2:0] control_event;
    logic [1:0] cooldown_event;

    modport source (
        output valid, heater_on, fan_on, status_led, status_valid, status_code,
               control_event, cooldown_event,
        input  ready
    );
    modport sink (
        input  valid, heater_on, fan_on, status_led, status_valid, status_code,
               control_event, cooldown_event,
        output ready
    );
endinterface

>>> rtl/core/hkc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module hkc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hkc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkc_pkg::CFG_DATA_W-1:0] cfg_data,
    output hkc_pkg::cfg_t                  cfg
);
    import hkc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KA_LOST:   cfg_next.ka_lost   = cfg_data[AGE_W-1:0];
                REG_KA_GOOD:   cfg_next.ka_good   = cfg_data[AGE_W-1:0];
                REG_COOL_LIM:  cfg_next.cool_lim  = cfg_data[AGE_W-1:0];
                REG_COOL_TEMP: cfg_next.cool_temp = cfg_data[TEMP_W-1:0];
                REG_HOT_TEMP:  cfg_next.hot_temp  = cfg_data[TEMP_W-1:0];
                REG_PERIOD:    cfg_next.period    = cfg_data[PERIOD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ka_lost   <= KA_LOST_RST;
            cfg_reg.ka_good   <= KA_GOOD_RST;
            cfg_reg.cool_lim  <= COOL_LIM_RST;
            cfg_reg.cool_temp <= COOL_TEMP_RST;
            cfg_reg.hot_temp  <= HOT_TEMP_RST;
            cfg_reg.period    <= PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/hkc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_core
// controller state and single-pass update: ages, link hysteresis, event
// priority chain, cooldown end and status report
// ----------------------------------------------------------------------------
module hkc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hkc_pkg::item_t   item,
    input  hkc_pkg::cfg_t    cfg,
    output hkc_pkg::result_t result
);
    import hkc_pkg::*;

    logic [AGE_W-1:0]    ka_age_reg,   ka_age_next;
    logic [AGE_W-1:0]    cd_age_reg,   cd_age_next;
    logic [PERIOD_W-1:0] pass_cnt_reg, pass_cnt_next;
    logic link_good_reg, link_good_next;
    logic heat_act_reg,  heat_act_next;
    logic cooling_reg,   cooling_next;
    logic link_lost_reg, link_lost_next;
    logic heater_reg,    heater_next;
    logic fan_reg,       fan_next;
    logic lamp_reg,      lamp_next;

    function automatic logic [AGE_W-1:0] sat_age(
        input logic [AGE_W-1:0]    a,
        input logic [ELAPSE_W-1:0] b
    );
        logic [AGE_W:0] s;
        s = {1'b0, a} + {{(AGE_W+1-ELAPSE_W){1'b0}}, b};
        return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
    endfunction

    always_comb
    begin
        ka_age_next    = ka_age_reg;
        cd_age_next    = sat_age(cd_age_reg, item.elapsed_ms);
        pass_cnt_next  = pass_cnt_reg;
        link_good_next = link_good_reg;
        heat_act_next  = heat_act_reg;
        cooling_next   = cooling_reg;
        link_lost_next = link_lost_reg;
        heater_next    = heater_reg;
        fan_next       = fan_reg;
        lamp_next      = lamp_reg;
        result.status_valid   = 1'b0;
        result.status_code    = STAT_OFF;
        result.control_event  = CEV_NONE;
        result.cooldown_event = KEV_NONE;

        if (item.mode == MODE_REFRESH)
        begin
            ka_age_next = '0;
        end
        else
        begin
            if (pass_cnt_reg != PASS_MAX)
            begin
                pass_cnt_next = pass_cnt_reg + 1'b1;
            end
            ka_age_next = sat_age(ka_age_reg, item.elapsed_ms);
            priority if (ka_age_next > cfg.ka_lost)
            begin
                link_good_next = 1'b0;
            end
            else if (ka_age_next < cfg.ka_good)
            begin
                link_good_next = 1'b1;
            end
            else
            begin
                link_good_next = link_good_reg;
            end

            // event priority chain
            priority if (heat_act_reg && !item.heat_request && !cooling_reg)
            begin
                heater_next  = 1'b0;
                cooling_next = 1'b1;
                cd_age_next  = '0;
                result.control_event = CEV_REQ_OFF;
            end
            else if (heat_act_reg && !link_good_next && !cooling_reg)
            begin
                heater_next    = 1'b0;
                cooling_next   = 1'b1;
                cd_age_next    = '0;
                link_lost_next = 1'b1;
                result.control_event = CEV_WDOG;
            end
            else if (link_lost_reg)
            begin
                if (link_good_next || !item.heat_request)
                begin
                    link_lost_next = 1'b0;
                    result.control_event = CEV_LINK_UP;
                end
            end
            else if (!heat_act_reg && item.heat_request && !cooling_reg && link_good_next)
            begin
                heater_next   = 1'b1;
                fan_next      = 1'b1;
                heat_act_next = 1'b1;
                result.control_event = CEV_REQ_ON;
            end
            else
            begin
                result.control_event = CEV_NONE;
            end

            // status report
            if (pass_cnt_next >= cfg.period)
            begin
                if (cooling_next)
                begin
                    priority if (item.temperature_f < cfg.cool_temp)
                    begin
                        result.cooldown_event = KEV_COOL;
                    end
                    else if (cd_age_next > cfg.cool_lim && !heater_next)
                    begin
                        result.cooldown_event = KEV_TIMER;
                    end
                    else
                    begin
                        result.cooldown_event = KEV_NONE;
                    end
                    if (result.cooldown_event != KEV_NONE)
                    begin
                        fan_next      = 1'b0;
                        cooling_next  = 1'b0;
                        heat_act_next = 1'b0;
                    end
                end
                priority if (heater_next && fan_next && heat_act_next
                             && item.temperature_f > cfg.hot_temp)
                begin
                    lamp_next = 1'b1;
                    result.status_code = STAT_ON;
                end
                else if (heater_next && fan_next && heat_act_next)
                begin
                    result.status_code = STAT_STARTING;
                end
                else if (fan_next)
                begin
                    result.status_code = STAT_FAN;
                end
                else
                begin
                    lamp_next = 1'b0;
                    result.status_code = STAT_OFF;
                end
                result.status_valid = 1'b1;
                pass_cnt_next = '0;
            end
        end

        result.heater_on  = heater_next;
        result.fan_on     = fan_next;
        result.status_led = lamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka_age_reg    <= '0;
            cd_age_reg    <= '0;
            pass_cnt_reg  <= '0;
            link_good_reg <= 1'b0;
            heat_act_reg  <= 1'b0;
            cooling_reg   <= 1'b0;
            link_lost_reg <= 1'b0;
            heater_reg    <= 1'b0;
            fan_reg       <= 1'b0;
            lamp_reg      <= 1'b0;
        end
        else if (step)
        begin
            ka_age_reg    <= ka_age_next;
            cd_age_reg    <= cd_age_next;
            pass_cnt_reg  <= pass_cnt_next;
            link_good_reg <= link_good_next;
            heat_act_reg  <= heat_act_next;
            cooling_reg   <= cooling_next;
            link_lost_reg <= link_lost_next;
            heater_reg    <= heater_next;
            fan_reg       <= fan_next;
            lamp_reg      <= lamp_next;
        end
    end

endmodule

>>> rtl/core/heater_keepalive_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_keepalive_controller_top
// heater and fan sequencer with keep-alive watchdog, one result word per
// input word
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   item     | in  | valid/ready   | mode, elapsed_ms, heat_request,
//            |     |               | temperature_f
//   result   | out | valid/ready   | heater_on, fan_on, status_led,
//            |     |               | status_valid, status_code, control_event,
//            |     |               | cooldown_event
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// one word per cycle sustained while the result side accepts; a word is captured in
// the input register and its result is then written into the result register
// the state update is a single combinational pass between those registers
// reset clears the controller state and valid flags and loads the register
// defaults; no clearing pass; a stalled result holds the result register and,
// once the input register is full, drops item.ready
// ----------------------------------------------------------------------------
module heater_keepalive_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    hkc_item_if.sink                       item,
    hkc_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [hkc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hkc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    logic    res_vld_reg;
    result_t res_next;
    logic    step;

    hkc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hkc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    assign step       = item_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !item_vld_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_vld_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            item_reg.mode          <= item.mode;
            item_reg.elapsed_ms    <= item.elapsed_ms;
            item_reg.heat_request  <= item.heat_request;
            item_reg.temperature_f <= item.temperature_f;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (step)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_vld_reg;
    assign result.heater_on      = res_reg.heater_on;
    assign result.fan_on         = res_reg.fan_on;
    assign result.status_led     = res_reg.status_led;
    assign result.status_valid   = res_reg.status_valid;
    assign result.status_code    = res_reg.status_code;
    assign result.control_event  = res_reg.control_event;
    assign result.cooldown_event = res_reg.cooldown_event;

endmodule
